// ----- sv/lts_pkg.sv -----
package lts_pkg;

  localparam int NUM_KEYWORDS      = 9;
  localparam int KEYWORD_MAX_CHARS = 8;
  localparam int LINE_BITS         = 16;

  localparam int CNT_W    = 5;
  localparam int KW_IDX_W = 4;
  localparam int KPOS_W   = $clog2(KEYWORD_MAX_CHARS);

  localparam logic [CNT_W-1:0] MAX_INT_DIGITS_RST = 5'd10;
  localparam logic [CNT_W-1:0] MAX_IDENT_LEN_RST  = 5'd20;

  // Configuration register indexes
  localparam logic CFG_MAX_INT_DIGITS = 1'b0;
  localparam logic CFG_MAX_IDENT_LEN  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_NUL        = 8'h00;

  // Keyword spellings, zero padded
  localparam logic [7:0] KW_CHARS [NUM_KEYWORDS][KEYWORD_MAX_CHARS] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // int
    '{8'h6D, 8'h6F, 8'h76, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // move
    '{8'h74, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // to
    '{8'h6C, 8'h6F, 8'h6F, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // loop
    '{8'h74, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00},  // times
    '{8'h6F, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // out
    '{8'h6E, 8'h65, 8'h77, 8'h6C, 8'h69, 8'h6E, 8'h65, 8'h00},  // newline
    '{8'h61, 8'h64, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // add
    '{8'h73, 8'h75, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // sub
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MINUS,
    MODE_INT,
    MODE_IDENT,
    MODE_STRING,
    MODE_COMMENT,
    MODE_HALT
  } mode_e;

  typedef enum logic [3:0] {
    EVT_BYTE      = 4'd0,
    EVT_INT       = 4'd1,
    EVT_STRING    = 4'd2,
    EVT_KEYWORD   = 4'd3,
    EVT_IDENT     = 4'd4,
    EVT_ENDLINE   = 4'd5,
    EVT_SEPARATOR = 4'd6,
    EVT_OPEN      = 4'd7,
    EVT_CLOSE     = 4'd8,
    EVT_EOF       = 4'd9,
    EVT_ERROR     = 4'd10
  } evt_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_INT_LONG     = 3'd1,
    ERR_MINUS_BLANK  = 3'd2,
    ERR_MINUS_NODIG  = 3'd3,
    ERR_UNTERMINATED = 3'd4,
    ERR_IDENT_LONG   = 3'd5,
    ERR_BAD_CHAR     = 3'd6
  } err_code_e;

  typedef struct packed {
    evt_kind_e             kind;
    logic [7:0]            lex_byte;
    logic [KW_IDX_W-1:0]   kw_idx;
    err_code_e             err;
    logic                  dec_warn;
    logic [LINE_BITS-1:0]  line;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r1;
    res_t       r0;
  } push_t;

  typedef struct packed {
    mode_e                mode;
    logic [LINE_BITS-1:0] line;
  } stat_t;

endpackage

// ----- sv/lts_kw_match.sv -----
module lts_kw_match (
  input  logic [lts_pkg::NUM_KEYWORDS-1:0] cand_i,
  input  logic [lts_pkg::CNT_W-1:0]        pos_i,
  input  logic [7:0]                       char_i,
  output logic [lts_pkg::NUM_KEYWORDS-1:0] cand_o,
  output logic                             hit_o,
  output logic [lts_pkg::KW_IDX_W-1:0]     idx_o
);

  logic in_range;
  logic [lts_pkg::KPOS_W-1:0] pos;

  assign in_range = pos_i < lts_pkg::CNT_W'(lts_pkg::KEYWORD_MAX_CHARS);
  assign pos      = pos_i[lts_pkg::KPOS_W-1:0];

  // Narrow the candidate set by the next character
  always_comb begin
    for (int k = 0; k < lts_pkg::NUM_KEYWORDS; k++) begin
      cand_o[k] = cand_i[k] && in_range && (lts_pkg::KW_CHARS[k][pos] == char_i);
    end
  end

  // Lowest-numbered candidate whose spelling ends here wins
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int k = lts_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (cand_i[k] && (!in_range || lts_pkg::KW_CHARS[k][pos] == lts_pkg::CH_NUL)) begin
        hit_o = 1'b1;
        idx_o = lts_pkg::KW_IDX_W'(k);
      end
    end
  end

endmodule

// ----- sv/lts_scan_core.sv -----
module lts_scan_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                char_i,
  input  logic                      eof_i,
  input  logic [lts_pkg::CNT_W-1:0] max_int_i,
  input  logic [lts_pkg::CNT_W-1:0] max_ident_i,
  output lts_pkg::push_t            push_o,
  output lts_pkg::stat_t            stat_o
);

  lts_pkg::mode_e                    mode_q, mode_d;
  logic [lts_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [lts_pkg::NUM_KEYWORDS-1:0]  cand_q, cand_d;
  logic [lts_pkg::LINE_BITS-1:0]     line_q, line_d;

  logic [lts_pkg::NUM_KEYWORDS-1:0]  kw_cand_in, kw_cand_out;
  logic [lts_pkg::CNT_W-1:0]         kw_pos;
  logic                              kw_hit;
  logic [lts_pkg::KW_IDX_W-1:0]      kw_idx;

  lts_pkg::res_t a_res, b_res;
  logic          a_vld, b_vld, to_idle, halt;
  logic          is_dig, is_let, is_ws;

  function automatic lts_pkg::res_t mk_res(lts_pkg::evt_kind_e kind, logic [7:0] b,
                                           logic [lts_pkg::KW_IDX_W-1:0] kw,
                                           lts_pkg::err_code_e err, logic dw,
                                           logic [lts_pkg::LINE_BITS-1:0] line);
    lts_pkg::res_t r;
    r.kind     = kind;
    r.lex_byte = b;
    r.kw_idx   = kw;
    r.err      = err;
    r.dec_warn = dw;
    r.line     = line;
    r.last     = 1'b0;
    return r;
  endfunction

  // A new word starts with all keywords as candidates at position zero
  assign kw_cand_in = (mode_q == lts_pkg::MODE_IDENT) ? cand_q : '1;
  assign kw_pos     = (mode_q == lts_pkg::MODE_IDENT) ? cnt_q : '0;

  lts_kw_match u_kw_match (
    .cand_i (kw_cand_in),
    .pos_i  (kw_pos),
    .char_i (char_i),
    .cand_o (kw_cand_out),
    .hit_o  (kw_hit),
    .idx_o  (kw_idx)
  );

  assign is_dig = (char_i >= lts_pkg::CH_DIGIT_0) && (char_i <= lts_pkg::CH_DIGIT_9);
  assign is_let = ((char_i >= lts_pkg::CH_LOWER_A) && (char_i <= lts_pkg::CH_LOWER_Z)) ||
                  ((char_i >= lts_pkg::CH_UPPER_A) && (char_i <= lts_pkg::CH_UPPER_Z));
  assign is_ws  = (char_i == lts_pkg::CH_SPACE) || (char_i == lts_pkg::CH_TAB) ||
                  (char_i == lts_pkg::CH_LF) || (char_i == lts_pkg::CH_RBRACE);

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    cand_d  = cand_q;
    line_d  = line_q;
    a_vld   = 1'b0;
    b_vld   = 1'b0;
    a_res   = mk_res(lts_pkg::EVT_BYTE, char_i, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
    b_res   = a_res;
    to_idle = 1'b0;
    halt    = 1'b0;

    // First phase: the mode in force when the character arrives
    unique case (mode_q)
      lts_pkg::MODE_MINUS: begin
        a_vld = 1'b1;
        if (eof_i) begin
          a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_MINUS_NODIG, 1'b0, line_q);
          halt  = 1'b1;
        end else if (char_i == lts_pkg::CH_SPACE) begin
          a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_MINUS_BLANK, 1'b0, line_q);
          halt  = 1'b1;
        end else if (is_dig) begin
          if (max_int_i == '0) begin
            a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_INT_LONG, 1'b0, line_q);
            halt  = 1'b1;
          end else begin
            cnt_d  = lts_pkg::CNT_W'(1);
            mode_d = lts_pkg::MODE_INT;
          end
        end else begin
          a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_MINUS_NODIG, 1'b0, line_q);
          halt  = 1'b1;
        end
      end
      lts_pkg::MODE_INT: begin
        a_vld = 1'b1;
        if (!eof_i && is_dig) begin
          if (cnt_q >= max_int_i) begin
            a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_INT_LONG, 1'b0, line_q);
            halt  = 1'b1;
          end else begin
            cnt_d = cnt_q + lts_pkg::CNT_W'(1);
          end
        end else begin
          a_res   = mk_res(lts_pkg::EVT_INT, '0, '0, lts_pkg::ERR_NONE,
                           !eof_i && (char_i == lts_pkg::CH_DOT || char_i == lts_pkg::CH_COMMA),
                           line_q);
          to_idle = 1'b1;
        end
      end
      lts_pkg::MODE_IDENT: begin
        a_vld = 1'b1;
        if (!eof_i && (is_let || is_dig || char_i == lts_pkg::CH_UNDERSCORE)) begin
          if (cnt_q >= max_ident_i) begin
            a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_IDENT_LONG, 1'b0, line_q);
            halt  = 1'b1;
          end else begin
            cand_d = kw_cand_out;
            cnt_d  = cnt_q + lts_pkg::CNT_W'(1);
          end
        end else begin
          if (kw_hit) begin
            a_res = mk_res(lts_pkg::EVT_KEYWORD, '0, kw_idx, lts_pkg::ERR_NONE, 1'b0, line_q);
          end else begin
            a_res = mk_res(lts_pkg::EVT_IDENT, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
          end
          to_idle = 1'b1;
        end
      end
      lts_pkg::MODE_STRING: begin
        a_vld = 1'b1;
        if (eof_i) begin
          a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_UNTERMINATED, 1'b0, line_q);
          halt  = 1'b1;
        end else if (char_i == lts_pkg::CH_QUOTE) begin
          // Echo the closing quote, then close the string
          b_vld  = 1'b1;
          b_res  = mk_res(lts_pkg::EVT_STRING, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
          mode_d = lts_pkg::MODE_IDLE;
        end
      end
      lts_pkg::MODE_COMMENT: begin
        if (eof_i) begin
          a_vld = 1'b1;
          a_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_UNTERMINATED, 1'b0, line_q);
          halt  = 1'b1;
        end else if (char_i == lts_pkg::CH_RBRACE) begin
          mode_d = lts_pkg::MODE_IDLE;
        end
      end
      lts_pkg::MODE_HALT: begin
        mode_d = lts_pkg::MODE_HALT;
      end
      default: begin
        to_idle = 1'b1;
      end
    endcase

    // Second phase: treat the character as arriving between tokens
    if (to_idle) begin
      mode_d = lts_pkg::MODE_IDLE;
      cnt_d  = '0;
      cand_d = '0;
      if (eof_i) begin
        b_vld  = 1'b1;
        b_res  = mk_res(lts_pkg::EVT_EOF, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
        line_d = lts_pkg::LINE_BITS'(1);
      end else if (is_ws) begin
        b_vld = 1'b0;
      end else if (is_dig) begin
        b_vld = 1'b1;
        if (max_int_i == '0) begin
          b_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_INT_LONG, 1'b0, line_q);
          halt  = 1'b1;
        end else begin
          cnt_d  = lts_pkg::CNT_W'(1);
          mode_d = lts_pkg::MODE_INT;
        end
      end else if (char_i == lts_pkg::CH_MINUS) begin
        b_vld  = 1'b1;
        mode_d = lts_pkg::MODE_MINUS;
      end else if (char_i == lts_pkg::CH_DOT) begin
        b_vld = 1'b1;
        b_res = mk_res(lts_pkg::EVT_ENDLINE, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
      end else if (char_i == lts_pkg::CH_COMMA) begin
        b_vld = 1'b1;
        b_res = mk_res(lts_pkg::EVT_SEPARATOR, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
      end else if (char_i == lts_pkg::CH_LBRACKET) begin
        b_vld = 1'b1;
        b_res = mk_res(lts_pkg::EVT_OPEN, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
      end else if (char_i == lts_pkg::CH_RBRACKET) begin
        b_vld = 1'b1;
        b_res = mk_res(lts_pkg::EVT_CLOSE, '0, '0, lts_pkg::ERR_NONE, 1'b0, line_q);
      end else if (char_i == lts_pkg::CH_LBRACE) begin
        mode_d = lts_pkg::MODE_COMMENT;
      end else if (char_i == lts_pkg::CH_QUOTE) begin
        b_vld  = 1'b1;
        mode_d = lts_pkg::MODE_STRING;
      end else if (is_let) begin
        b_vld = 1'b1;
        if (max_ident_i == '0) begin
          b_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_IDENT_LONG, 1'b0, line_q);
          halt  = 1'b1;
        end else begin
          cand_d = kw_cand_out;
          cnt_d  = lts_pkg::CNT_W'(1);
          mode_d = lts_pkg::MODE_IDENT;
        end
      end else begin
        b_vld = 1'b1;
        b_res = mk_res(lts_pkg::EVT_ERROR, '0, '0, lts_pkg::ERR_BAD_CHAR, 1'b0, line_q);
        halt  = 1'b1;
      end
    end

    if (halt) begin
      mode_d = lts_pkg::MODE_HALT;
    end

    // Count lines after the results, saturating
    if (!eof_i && char_i == lts_pkg::CH_LF && !halt && mode_q != lts_pkg::MODE_HALT &&
        line_q != '1) begin
      line_d = line_q + lts_pkg::LINE_BITS'(1);
    end

    // Pack the results into slots, earliest first
    if (a_vld) begin
      push_o.r0 = a_res;
      push_o.r1 = b_res;
      push_o.n  = b_vld ? 2'd2 : 2'd1;
    end else begin
      push_o.r0 = b_res;
      push_o.r1 = b_res;
      push_o.n  = {1'b0, b_vld};
    end
    push_o.r0.last = (push_o.n == 2'd1);
    push_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lts_pkg::MODE_IDLE;
      cnt_q  <= '0;
      cand_q <= '0;
      line_q <= lts_pkg::LINE_BITS'(1);
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      cand_q <= cand_d;
      line_q <= line_d;
    end
  end

  assign stat_o.mode = mode_q;
  assign stat_o.line = line_q;

endmodule

// ----- sv/lts_res_fifo.sv -----
module lts_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lts_pkg::push_t push_i,
  input  logic           pop_i,
  output logic [1:0]     free_o,
  output logic           valid_o,
  output lts_pkg::res_t  head_o
);

  lts_pkg::res_t slot_q [2];
  lts_pkg::res_t slot_d [2];
  logic [1:0]    count_q, count_d, rem;

  assign rem     = count_q - {1'b0, pop_i};
  assign free_o  = 2'd2 - rem;
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[0];

  // Drop the popped entry, then append the new results behind what remains
  always_comb begin
    slot_d[0] = pop_i ? slot_q[1] : slot_q[0];
    slot_d[1] = slot_q[1];
    case (rem)
      2'd0: begin
        slot_d[0] = push_i.r0;
        slot_d[1] = push_i.r1;
      end
      2'd1: begin
        slot_d[1] = push_i.r0;
      end
      default: begin
        slot_d[1] = slot_q[1];
      end
    endcase
    count_d = rem + push_i.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

// ----- sv/lexical_token_scanner.sv -----
// A character's first result passes the input register, then the result queue, before its
//   master-side transaction; a second result, if any, follows it.
// Throughput: one character per cycle while the master side keeps up; a character with
//   two results can hold the slave side back, as the single result port takes them in turn.
// Reset: asynchronous, active low; scanner returns to idle, line one, limits 10 and 20.
module lexical_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: tdata = char_code[7:0]; tuser = end_of_input[0]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  // Master side: tdata = lexeme_byte[7:0], keyword_index[11:8], error_code[14:12],
  //   decimal_warning[15], line_number[31:16]; tuser = event_kind[3:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i
);

  // Configuration registers
  logic [lts_pkg::CNT_W-1:0] max_int_q, max_ident_q;

  // Input register: one character waiting for the scanner
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eof_q;

  logic           consume;
  logic           s_accept;
  logic           pop;
  logic [1:0]     free;
  lts_pkg::push_t core_push;
  lts_pkg::push_t fifo_push;
  lts_pkg::stat_t core_stat;
  lts_pkg::res_t  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_int_q   <= lts_pkg::MAX_INT_DIGITS_RST;
      max_ident_q <= lts_pkg::MAX_IDENT_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lts_pkg::CFG_MAX_INT_DIGITS: max_int_q   <= cfg_wdata_i;
        lts_pkg::CFG_MAX_IDENT_LEN:  max_ident_q <= cfg_wdata_i;
        default:                     max_int_q   <= max_int_q;
      endcase
    end
  end

  // Advance the held character only when the result queue has room for all of
  // its results, counting the slot freed by this cycle's output transaction.
  assign consume         = in_valid_q && (core_push.n <= free);
  assign s_axis_tready_o = !in_valid_q || consume;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata_i;
      in_eof_q  <= s_axis_tuser_i;
    end
  end

  lts_scan_core u_scan_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (consume),
    .char_i      (in_char_q),
    .eof_i       (in_eof_q),
    .max_int_i   (max_int_q),
    .max_ident_i (max_ident_q),
    .push_o      (core_push),
    .stat_o      (core_stat)
  );

  // Push nothing unless the character is really taken
  always_comb begin
    fifo_push   = core_push;
    fifo_push.n = consume ? core_push.n : 2'd0;
  end

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  lts_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .pop_i   (pop),
    .free_o  (free),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {head.line, head.dec_warn, head.err, head.kw_idx, head.lex_byte};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

  // A consumed character never overruns the result queue
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |-> (core_push.n <= free))
    else $error("result queue overrun");

  // Once halted, the scanner produces nothing
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_stat.mode == lts_pkg::MODE_HALT) |-> (core_push.n == 2'd0))
    else $error("results while halted");

  // End of input between or at the end of a token restarts line counting
  a_eof_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_eof_q && (core_stat.mode == lts_pkg::MODE_IDLE ||
     core_stat.mode == lts_pkg::MODE_INT || core_stat.mode == lts_pkg::MODE_IDENT))
    |=> (core_stat.line == lts_pkg::LINE_BITS'(1)))
    else $error("line count not restarted at end of input");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

  // Scanner state as the checker tracks it, limits included.
  typedef struct {
    lts_pkg::mode_e                   mode;
    logic [lts_pkg::CNT_W-1:0]        cnt;
    logic [lts_pkg::NUM_KEYWORDS-1:0] cand;
    logic [lts_pkg::LINE_BITS-1:0]    line;
    logic [lts_pkg::CNT_W-1:0]        int_lim;
    logic [lts_pkg::CNT_W-1:0]        id_lim;
  } scan_st_t;

  // One row of the directed character table. Rows with a hand-typed outcome carry
  // the number of events (zero or one) and that event's kind, byte and line.
  typedef struct {
    logic [7:0]                    c;
    logic                          eoi;
    logic                          typed;
    int                            n;
    lts_pkg::evt_kind_e            kind;
    logic [7:0]                    lb;
    logic [lts_pkg::LINE_BITS-1:0] ln;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = lts_pkg::CFG_MAX_INT_DIGITS;
  logic [4:0]  cfg_wdata = 5'd0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  scan_st_t      scan_ref;
  lts_pkg::res_t pending_events [$];
  lts_pkg::res_t oldest;
  dir_row_t      dir_tab [25];
  int            fails = 0;
  int            n_items = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  lexical_token_scanner u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: several times beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("lexical_token_scanner regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_dig(logic [7:0] c);
    return c >= lts_pkg::CH_DIGIT_0 && c <= lts_pkg::CH_DIGIT_9;
  endfunction

  function automatic logic is_let(logic [7:0] c);
    return (c >= lts_pkg::CH_LOWER_A && c <= lts_pkg::CH_LOWER_Z) ||
           (c >= lts_pkg::CH_UPPER_A && c <= lts_pkg::CH_UPPER_Z);
  endfunction

  // Keep only the keywords whose spelling has character c at position pos.
  function automatic logic [lts_pkg::NUM_KEYWORDS-1:0] next_cand(
      logic [lts_pkg::NUM_KEYWORDS-1:0] cand, logic [lts_pkg::CNT_W-1:0] pos,
      logic [7:0] c);
    logic [lts_pkg::NUM_KEYWORDS-1:0] r;
    r = '0;
    for (int k = 0; k < lts_pkg::NUM_KEYWORDS; k++)
      r[k] = cand[k] && pos < lts_pkg::KEYWORD_MAX_CHARS &&
             lts_pkg::KW_CHARS[k][pos[lts_pkg::KPOS_W-1:0]] == c;
    return r;
  endfunction

  function automatic void add_res(inout lts_pkg::res_t rs [2], inout int n,
                                  input lts_pkg::evt_kind_e k, input logic [7:0] b,
                                  input logic [lts_pkg::KW_IDX_W-1:0] kw,
                                  input lts_pkg::err_code_e e, input logic dw,
                                  input logic [lts_pkg::LINE_BITS-1:0] ln);
    rs[n] = '{kind: k, lex_byte: b, kw_idx: kw, err: e, dec_warn: dw, line: ln, last: 1'b0};
    n++;
  endfunction

  // A fatal error reports itself and freezes the scanner until reset.
  function automatic void raise(inout scan_st_t st, inout lts_pkg::res_t rs [2],
                                inout int n, input lts_pkg::err_code_e e,
                                input logic [lts_pkg::LINE_BITS-1:0] ln);
    add_res(rs, n, lts_pkg::EVT_ERROR, 8'h00, '0, e, 1'b0, ln);
    st.mode = lts_pkg::MODE_HALT;
  endfunction

  // Advance the scanner by one character (or end of input) and return the events
  // it must emit, in order; the last one carries tlast.
  function automatic int scan_char(inout scan_st_t st, input logic [7:0] c, input logic eoi,
                                   output lts_pkg::res_t rs [2]);
    int                            n;
    logic                          to_idle;
    logic                          found;
    logic [lts_pkg::LINE_BITS-1:0] ln;
    n = 0;
    to_idle = 1'b0;
    found = 1'b0;
    ln = st.line;
    rs[0] = '0;
    rs[1] = '0;
    if (st.mode == lts_pkg::MODE_HALT) return 0;

    case (st.mode)
      lts_pkg::MODE_MINUS: begin
        if (!eoi && c == lts_pkg::CH_SPACE) raise(st, rs, n, lts_pkg::ERR_MINUS_BLANK, ln);
        else if (eoi || !is_dig(c)) raise(st, rs, n, lts_pkg::ERR_MINUS_NODIG, ln);
        else if (st.int_lim == 0) raise(st, rs, n, lts_pkg::ERR_INT_LONG, ln);
        else begin
          add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
          st.cnt = 1;
          st.mode = lts_pkg::MODE_INT;
        end
      end
      lts_pkg::MODE_INT: begin
        if (!eoi && is_dig(c)) begin
          if (st.cnt >= st.int_lim) raise(st, rs, n, lts_pkg::ERR_INT_LONG, ln);
          else begin
            add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
            st.cnt++;
          end
        end else begin
          // A decimal point or comma right after the digits flags a warning.
          add_res(rs, n, lts_pkg::EVT_INT, 8'h00, '0, lts_pkg::ERR_NONE,
                  !eoi && (c == lts_pkg::CH_DOT || c == lts_pkg::CH_COMMA), ln);
          st.mode = lts_pkg::MODE_IDLE;
          to_idle = 1'b1;
        end
      end
      lts_pkg::MODE_IDENT: begin
        if (!eoi && (is_let(c) || is_dig(c) || c == lts_pkg::CH_UNDERSCORE)) begin
          if (st.cnt >= st.id_lim) raise(st, rs, n, lts_pkg::ERR_IDENT_LONG, ln);
          else begin
            add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
            st.cand = next_cand(st.cand, st.cnt, c);
            st.cnt++;
          end
        end else begin
          // First surviving keyword whose spelling ends here wins.
          for (int k = 0; k < lts_pkg::NUM_KEYWORDS; k++) begin
            if (!found && st.cand[k] &&
                (st.cnt >= lts_pkg::KEYWORD_MAX_CHARS ||
                 lts_pkg::KW_CHARS[k][st.cnt[lts_pkg::KPOS_W-1:0]] == lts_pkg::CH_NUL)) begin
              add_res(rs, n, lts_pkg::EVT_KEYWORD, 8'h00, lts_pkg::KW_IDX_W'(k),
                      lts_pkg::ERR_NONE, 1'b0, ln);
              found = 1'b1;
            end
          end
          if (!found)
            add_res(rs, n, lts_pkg::EVT_IDENT, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
          st.mode = lts_pkg::MODE_IDLE;
          to_idle = 1'b1;
        end
      end
      lts_pkg::MODE_STRING: begin
        if (eoi) raise(st, rs, n, lts_pkg::ERR_UNTERMINATED, ln);
        else begin
          add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
          if (c == lts_pkg::CH_QUOTE) begin
            add_res(rs, n, lts_pkg::EVT_STRING, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
            st.mode = lts_pkg::MODE_IDLE;
          end
        end
      end
      lts_pkg::MODE_COMMENT: begin
        if (eoi) raise(st, rs, n, lts_pkg::ERR_UNTERMINATED, ln);
        else if (c == lts_pkg::CH_RBRACE) st.mode = lts_pkg::MODE_IDLE;
      end
      default: begin
        st.mode = lts_pkg::MODE_IDLE;
        to_idle = 1'b1;
      end
    endcase

    // Between tokens: the character (possibly the one that just closed a token)
    // starts something new, or end of input rewinds the scanner.
    if (to_idle) begin
      if (eoi) begin
        add_res(rs, n, lts_pkg::EVT_EOF, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
        st.cnt = 0;
        st.cand = '0;
        st.line = 1;
      end else begin
        st.cnt = 0;
        st.cand = '0;
        if (c inside {lts_pkg::CH_SPACE, lts_pkg::CH_TAB, lts_pkg::CH_LF,
                      lts_pkg::CH_RBRACE}) begin
          // blanks and a stray close brace pass silently
        end else if (is_dig(c)) begin
          if (st.int_lim == 0) raise(st, rs, n, lts_pkg::ERR_INT_LONG, ln);
          else begin
            add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
            st.cnt = 1;
            st.mode = lts_pkg::MODE_INT;
          end
        end else if (c == lts_pkg::CH_MINUS) begin
          add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
          st.mode = lts_pkg::MODE_MINUS;
        end else if (c == lts_pkg::CH_DOT) begin
          add_res(rs, n, lts_pkg::EVT_ENDLINE, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
        end else if (c == lts_pkg::CH_COMMA) begin
          add_res(rs, n, lts_pkg::EVT_SEPARATOR, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
        end else if (c == lts_pkg::CH_LBRACKET) begin
          add_res(rs, n, lts_pkg::EVT_OPEN, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
        end else if (c == lts_pkg::CH_RBRACKET) begin
          add_res(rs, n, lts_pkg::EVT_CLOSE, 8'h00, '0, lts_pkg::ERR_NONE, 1'b0, ln);
        end else if (c == lts_pkg::CH_LBRACE) begin
          st.mode = lts_pkg::MODE_COMMENT;
        end else if (c == lts_pkg::CH_QUOTE) begin
          add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
          st.mode = lts_pkg::MODE_STRING;
        end else if (is_let(c)) begin
          if (st.id_lim == 0) raise(st, rs, n, lts_pkg::ERR_IDENT_LONG, ln);
          else begin
            add_res(rs, n, lts_pkg::EVT_BYTE, c, '0, lts_pkg::ERR_NONE, 1'b0, ln);
            st.cand = next_cand('1, '0, c);
            st.cnt = 1;
            st.mode = lts_pkg::MODE_IDENT;
          end
        end else raise(st, rs, n, lts_pkg::ERR_BAD_CHAR, ln);
      end
    end

    // Newlines bump the line after this step's events; the counter saturates.
    if (!eoi && c == lts_pkg::CH_LF && st.mode != lts_pkg::MODE_HALT && st.line != '1)
      st.line++;
    if (n > 0) rs[n-1].last = 1'b1;
    return n;
  endfunction

  // True when the character would halt the scanner, or park it after a minus
  // sign that no digit can follow under the current limit.
  function automatic logic would_halt(scan_st_t st, logic [7:0] c, logic eoi);
    lts_pkg::res_t rs [2];
    void'(scan_char(st, c, eoi, rs));
    return st.mode == lts_pkg::MODE_HALT ||
           (st.mode == lts_pkg::MODE_MINUS && st.int_lim == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) m_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Hold one character on the slave side until its transaction completes,
  // idling first at the current sender rate.
  task automatic xfer_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_user  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Send a character and queue the events the predictor expects from it.
  task automatic feed(input logic [7:0] c, input logic eoi);
    lts_pkg::res_t rs [2];
    int            n;
    xfer_char(c, eoi);
    n = scan_char(scan_ref, c, eoi, rs);
    for (int i = 0; i < n; i++) pending_events.push_back(rs[i]);
    n_items++;
  endtask

  // Same, but swap a character that would halt the scanner for a harmless one.
  task automatic feed_safe(input logic [7:0] c, input logic eoi);
    logic [7:0] cc;
    logic       ee;
    cc = c;
    ee = eoi;
    if (would_halt(scan_ref, cc, ee)) begin
      cc = lts_pkg::CH_DIGIT_0;
      ee = 1'b0;
      if (would_halt(scan_ref, cc, ee)) cc = lts_pkg::CH_SPACE;
    end
    feed(cc, ee);
  endtask

  // Close whatever token is open so that the scanner sits between tokens.
  task automatic close_token();
    while (scan_ref.mode != lts_pkg::MODE_IDLE && scan_ref.mode != lts_pkg::MODE_HALT) begin
      case (scan_ref.mode)
        lts_pkg::MODE_MINUS:   feed(lts_pkg::CH_DIGIT_0, 1'b0);
        lts_pkg::MODE_STRING:  feed(lts_pkg::CH_QUOTE, 1'b0);
        lts_pkg::MODE_COMMENT: feed(lts_pkg::CH_RBRACE, 1'b0);
        default:               feed(lts_pkg::CH_SPACE, 1'b0);
      endcase
    end
  endtask

  // Wait for every expected event, then let the pipeline run dry.
  task automatic drain(input int tail);
    int guard;
    s_valid <= 1'b0;
    for (guard = 0; guard < 20000 && pending_events.size() != 0; guard++) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      fails++;
      pending_events.delete();
    end
  endtask

  task automatic load_limits(input logic [4:0] int_lim, input logic [4:0] id_lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= lts_pkg::CFG_MAX_INT_DIGITS;
    cfg_wdata <= int_lim;
    @(posedge clk_i);
    cfg_addr  <= lts_pkg::CFG_MAX_IDENT_LEN;
    cfg_wdata <= id_lim;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    scan_ref.int_lim = int_lim;
    scan_ref.id_lim  = id_lim;
  endtask

  // ---------------------------------------------------------------------------
  // Random token source
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? lts_pkg::CH_UPPER_A + 8'($urandom_range(25))
                             : lts_pkg::CH_LOWER_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(3))
      0, 1:    return rand_letter();
      2:       return lts_pkg::CH_DIGIT_0 + 8'($urandom_range(9));
      default: return lts_pkg::CH_UNDERSCORE;
    endcase
  endfunction

  // Character that ends a number or word; bit 8 is the end-of-input flag.
  function automatic logic [8:0] rand_term();
    case ($urandom_range(8))
      0:       return {1'b0, lts_pkg::CH_SPACE};
      1:       return {1'b0, lts_pkg::CH_TAB};
      2:       return {1'b0, lts_pkg::CH_LF};
      3:       return {1'b0, lts_pkg::CH_DOT};
      4:       return {1'b0, lts_pkg::CH_COMMA};
      5:       return {1'b0, lts_pkg::CH_LBRACKET};
      6:       return {1'b0, lts_pkg::CH_RBRACKET};
      7:       return {1'b1, 8'($urandom)};
      default: return {1'b0, lts_pkg::CH_RBRACE};
    endcase
  endfunction

  // Build one mostly well-formed token with random content and send it.
  task automatic emit_token();
    logic [8:0] seq [$];
    int         sel;
    int         len;
    int         k;
    sel = $urandom_range(99);
    if (sel < 22) begin
      // integer, sometimes negative, sometimes one digit past the limit
      if ($urandom_range(3) == 0) seq.push_back({1'b0, lts_pkg::CH_MINUS});
      len = $urandom_range((scan_ref.int_lim == 0) ? 1 : scan_ref.int_lim, 1);
      if ($urandom_range(7) == 0) len++;
      repeat (len) seq.push_back({1'b0, lts_pkg::CH_DIGIT_0 + 8'($urandom_range(9))});
      if ($urandom_range(4) != 0) seq.push_back(rand_term());
    end else if (sel < 44) begin
      if ($urandom_range(1)) begin
        // keyword, exact or with a character cut off or added
        k = $urandom_range(lts_pkg::NUM_KEYWORDS - 1);
        for (int p = 0; p < lts_pkg::KEYWORD_MAX_CHARS; p++)
          if (lts_pkg::KW_CHARS[k][p] != lts_pkg::CH_NUL)
            seq.push_back({1'b0, lts_pkg::KW_CHARS[k][p]});
        case ($urandom_range(3))
          0:       if (seq.size() > 1) void'(seq.pop_back());
          1:       seq.push_back({1'b0, rand_word_char()});
          default: ;
        endcase
      end else begin
        len = $urandom_range((scan_ref.id_lim == 0) ? 1 : scan_ref.id_lim, 1);
        if ($urandom_range(7) == 0) len++;
        seq.push_back({1'b0, rand_letter()});
        repeat (len - 1) seq.push_back({1'b0, rand_word_char()});
      end
      if ($urandom_range(4) != 0) seq.push_back(rand_term());
    end else if (sel < 54) begin
      seq.push_back({1'b0, lts_pkg::CH_QUOTE});
      repeat ($urandom_range(6)) seq.push_back({1'b0, 8'($urandom)});
      seq.push_back({1'b0, lts_pkg::CH_QUOTE});
    end else if (sel < 62) begin
      seq.push_back({1'b0, lts_pkg::CH_LBRACE});
      repeat ($urandom_range(6)) seq.push_back({1'b0, 8'($urandom)});
      seq.push_back({1'b0, lts_pkg::CH_RBRACE});
    end else if (sel < 78) begin
      case ($urandom_range(4))
        0:       seq.push_back({1'b0, lts_pkg::CH_DOT});
        1:       seq.push_back({1'b0, lts_pkg::CH_COMMA});
        2:       seq.push_back({1'b0, lts_pkg::CH_LBRACKET});
        3:       seq.push_back({1'b0, lts_pkg::CH_RBRACKET});
        default: seq.push_back({1'b0, lts_pkg::CH_RBRACE});
      endcase
    end else if (sel < 88) begin
      case ($urandom_range(2))
        0:       seq.push_back({1'b0, lts_pkg::CH_SPACE});
        1:       seq.push_back({1'b0, lts_pkg::CH_TAB});
        default: seq.push_back({1'b0, lts_pkg::CH_LF});
      endcase
    end else if (sel < 92) begin
      seq.push_back({1'b1, 8'($urandom)});
    end else begin
      // noise byte
      seq.push_back({1'($urandom_range(15) == 0), 8'($urandom)});
    end
    foreach (seq[i]) feed_safe(seq[i][7:0], seq[i][8]);
  endtask

  // ---------------------------------------------------------------------------
  // Checker: compare each master-side transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void chk(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fld, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d data %h", m_axis_tuser_o, m_axis_tdata_o);
        fails++;
      end else begin
        oldest = pending_events.pop_front();
        chk("event_kind", oldest.kind, m_axis_tuser_o);
        chk("lexeme_byte", oldest.lex_byte, m_axis_tdata_o[7:0]);
        chk("keyword_index", oldest.kw_idx, m_axis_tdata_o[11:8]);
        chk("error_code", oldest.err, m_axis_tdata_o[14:12]);
        chk("decimal_warning", oldest.dec_warn, m_axis_tdata_o[15]);
        chk("line_number", oldest.line, m_axis_tdata_o[31:16]);
        chk("last_of_run", oldest.last, m_axis_tlast_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    lts_pkg::res_t      rs [2];
    int                 n;
    int                 lim_i;
    int                 lim_w;
    lts_pkg::err_code_e want;
    logic [8:0]         tail_seq [$];

    // Directed characters. Hand-typed rows cover the punctuation from reset,
    // a stray close brace, a newline bump and a leading minus; the rest goes
    // through the predictor: integer ended by a decimal point, identifier with
    // both letter extremes and an underscore ended by a bracket, a string with
    // a 0xFF byte and a newline inside, a comment holding a zero byte, and a
    // keyword closed by end of input with a junk character code.
    dir_tab = '{
      '{lts_pkg::CH_DOT,        1'b0, 1'b1, 1, lts_pkg::EVT_ENDLINE,   8'h00, 16'd1},
      '{lts_pkg::CH_COMMA,      1'b0, 1'b1, 1, lts_pkg::EVT_SEPARATOR, 8'h00, 16'd1},
      '{lts_pkg::CH_LBRACKET,   1'b0, 1'b1, 1, lts_pkg::EVT_OPEN,      8'h00, 16'd1},
      '{lts_pkg::CH_RBRACKET,   1'b0, 1'b1, 1, lts_pkg::EVT_CLOSE,     8'h00, 16'd1},
      '{lts_pkg::CH_RBRACE,     1'b0, 1'b1, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd1},
      '{lts_pkg::CH_LF,         1'b0, 1'b1, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd1},
      '{lts_pkg::CH_MINUS,      1'b0, 1'b1, 1, lts_pkg::EVT_BYTE, lts_pkg::CH_MINUS, 16'd2},
      '{lts_pkg::CH_DIGIT_9,    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_DOT,        1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_UPPER_A,    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_LOWER_Z,    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_UNDERSCORE, 1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_DIGIT_0,    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_LBRACKET,   1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_QUOTE,      1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{8'hFF,                  1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_LF,         1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_QUOTE,      1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_LBRACE,     1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_NUL,        1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{lts_pkg::CH_RBRACE,     1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{"s",                    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{"u",                    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{"b",                    1'b0, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0},
      '{8'hA5,                  1'b1, 1'b0, 0, lts_pkg::EVT_BYTE,      8'h00, 16'd0}
    };

    scan_ref = '{mode: lts_pkg::MODE_IDLE, cnt: '0, cand: '0, line: 1,
                 int_lim: lts_pkg::MAX_INT_DIGITS_RST, id_lim: lts_pkg::MAX_IDENT_LEN_RST};

    // Hold reset at the start, then release it for good.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at the reset limits, sender mostly busy and receiver mostly stalled.
    send_idle_pct = 8;
    recv_idle_pct = 82;
    foreach (dir_tab[i]) begin
      xfer_char(dir_tab[i].c, dir_tab[i].eoi);
      n = scan_char(scan_ref, dir_tab[i].c, dir_tab[i].eoi, rs);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].n != 0)
          pending_events.push_back('{kind: dir_tab[i].kind, lex_byte: dir_tab[i].lb,
                                     kw_idx: '0, err: lts_pkg::ERR_NONE, dec_warn: 1'b0,
                                     line: dir_tab[i].ln, last: 1'b1});
      end else begin
        for (int j = 0; j < n; j++) pending_events.push_back(rs[j]);
      end
    end
    drain(4);

    // Random token streams, each segment under its own limits. Segments pair up
    // on the three idling profiles: busy sender with a stalling receiver, the
    // reverse, then both at full rate.
    for (int seg = 0; seg < 6; seg++) begin
      close_token();
      drain(4);
      case (seg)
        0:       begin lim_i = 1;                     lim_w = 1;                     end
        1:       begin lim_i = 20;                    lim_w = 31;                    end
        2:       begin lim_i = 0;                     lim_w = $urandom_range(31, 1); end
        3:       begin lim_i = $urandom_range(20, 1); lim_w = 0;                     end
        4:       begin lim_i = 31;                    lim_w = 8;                     end
        default: begin lim_i = $urandom_range(31);    lim_w = $urandom_range(31);    end
      endcase
      load_limits(5'(lim_i), 5'(lim_w));
      case (seg / 2)
        0:       begin send_idle_pct = 8;  recv_idle_pct = 82; end
        1:       begin send_idle_pct = 82; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      n = n_items + 250;
      while (n_items < n) emit_token();
    end

    // Close with one fatal error of a random kind, then show the scanner stays
    // silent whatever follows.
    close_token();
    drain(4);
    load_limits(5'd2, 5'd3);
    want = lts_pkg::err_code_e'($urandom_range(6, 1));
    case (want)
      lts_pkg::ERR_INT_LONG: begin
        repeat (3) tail_seq.push_back({1'b0, lts_pkg::CH_DIGIT_0 + 8'($urandom_range(9))});
      end
      lts_pkg::ERR_MINUS_BLANK: begin
        tail_seq.push_back({1'b0, lts_pkg::CH_MINUS});
        tail_seq.push_back({1'b0, lts_pkg::CH_SPACE});
      end
      lts_pkg::ERR_MINUS_NODIG: begin
        tail_seq.push_back({1'b0, lts_pkg::CH_MINUS});
        case ($urandom_range(2))
          0:       tail_seq.push_back({1'b0, rand_letter()});
          1:       tail_seq.push_back({1'b0, lts_pkg::CH_LF});
          default: tail_seq.push_back({1'b1, 8'($urandom)});
        endcase
      end
      lts_pkg::ERR_UNTERMINATED: begin
        tail_seq.push_back({1'b0, $urandom_range(1) ? lts_pkg::CH_QUOTE : lts_pkg::CH_LBRACE});
        tail_seq.push_back({1'b0, rand_letter()});
        tail_seq.push_back({1'b1, 8'($urandom)});
      end
      lts_pkg::ERR_IDENT_LONG: begin
        repeat (4) tail_seq.push_back({1'b0, rand_letter()});
      end
      default: begin
        case ($urandom_range(3))
          0:       tail_seq.push_back({1'b0, 8'h0D});  // carriage return
          1:       tail_seq.push_back({1'b0, lts_pkg::CH_NUL});
          2:       tail_seq.push_back({1'b0, 8'h40});  // '@'
          default: tail_seq.push_back({1'b0, 8'h80 | 8'($urandom)});
        endcase
      end
    endcase
    foreach (tail_seq[i]) feed(tail_seq[i][7:0], tail_seq[i][8]);
    repeat (6) feed(8'($urandom), 1'($urandom_range(1)));
    drain(20);

    if (fails == 0) begin
      $display("lexical_token_scanner regression: pass");
    end else begin
      $display("lexical_token_scanner regression: fail");
    end
    $finish;
  end

endmodule
